>>> design/rgbc_pkg.sv
// shared constants and types for the rgbc to hsl percent converter
`timescale 1ns / 1ps
package rgbc_pkg;
    localparam int QUOT_W   = 7;     // quotient bits produced by one divider chain
    localparam int PCT_W    = 7;     // percent values 0..100
    localparam int HSL_REM_W = 14;   // numerators of the hue and saturation divides
    localparam int HSL_DEN_W = 8;    // divisors of the hue and saturation divides
    localparam int HUE_W    = 9;

    localparam logic [PCT_W-1:0]     PCT_FULL  = 7'd100;
    localparam logic [PCT_W-1:0]     L_HALF    = 7'd50;
    localparam logic [HSL_DEN_W-1:0] SUM_FULL  = 8'd200;
    localparam logic [6:0]           HUE_SCALE = 7'd60;
    localparam logic [HUE_W-1:0]     HUE_RED   = 9'd360;
    localparam logic [HUE_W-1:0]     HUE_GREEN = 9'd120;
    localparam logic [HUE_W-1:0]     HUE_BLUE  = 9'd240;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        logic             err;
        logic [2:0]       clamp;   // red, green, blue at or above 128 percent
    } t_pct_side;

    typedef struct packed {
        logic             err;
        logic             grey;
        logic             neg;
        t_sector          sector;
        logic [PCT_W-1:0] light;
    } t_hsl_side;
endpackage

>>> design/rgbc_div_cell.sv
// one restoring division step: compares against the shifted divisor and passes on
`timescale 1ns / 1ps
module rgbc_div_cell
    import rgbc_pkg::*;
#(
    parameter int W  = 23,
    parameter int DW = 16,
    parameter int K  = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [W-1:0]      i_rem,
    input  logic [DW-1:0]     i_den,
    input  logic [QUOT_W-1:0] i_q,
    output logic [W-1:0]      o_rem,
    output logic [DW-1:0]     o_den,
    output logic [QUOT_W-1:0] o_q
);
    localparam int CW = (W > DW + K) ? W : DW + K;

    logic [CW-1:0]     w_rem_x;
    logic [CW-1:0]     w_den_x;
    logic              w_ge;
    logic [W-1:0]      n_rem;
    logic [QUOT_W-1:0] n_q;
    logic [W-1:0]      r_rem;
    logic [DW-1:0]     r_den;
    logic [QUOT_W-1:0] r_q;

    always_comb begin
        w_rem_x = CW'(i_rem);
        w_den_x = CW'(i_den) << K;
        w_ge    = (w_rem_x >= w_den_x);
        n_rem   = w_ge ? W'(w_rem_x - w_den_x) : i_rem;
        n_q     = {i_q[QUOT_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_q   <= n_q;
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_q   = r_q;
endmodule

>>> design/rgbc_to_hsl_percent.sv
// top level: rgbc sample to integer hue, saturation and lightness
`timescale 1ns / 1ps
// usage
//   input channel: i_valid / o_stall carries one request of red, green, blue and
//   clear counts; a request is taken at an edge with i_valid high and o_stall low
//   output channel: o_valid / i_stall carries hue, saturation, lightness and the
//   divide error flag, one result for every request, in order
//   path: input register, percent chain, mid register, hsl chain, output register
//   throughput: one request per cycle while o_stall is low, set by pipelined chains of seven
//   division cells (percent scaling, then hue and saturation), each cell one quotient bit
//   stalls: a result held by i_stall stays on the output register; one more result
//   goes into a skid register, and only while the skid is full is o_stall high and
//   the whole pipeline frozen
//   reset: synchronous active low, empties all stages; no results appear until new
//   requests arrive
//   a clear count of zero gives divide_error and zero hue, saturation, lightness
module rgbc_to_hsl_percent
    import rgbc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [SAMPLE_WIDTH-1:0] i_red_count,
    input  logic [SAMPLE_WIDTH-1:0] i_green_count,
    input  logic [SAMPLE_WIDTH-1:0] i_blue_count,
    input  logic [SAMPLE_WIDTH-1:0] i_clear_count,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [HUE_W-1:0]        o_hue,
    output logic [PCT_W-1:0]        o_saturation,
    output logic [PCT_W-1:0]        o_lightness,
    output logic                    o_divide_error
);
    localparam int SW = SAMPLE_WIDTH;
    localparam int NW = SW + QUOT_W;           // count times 100 fits here
    localparam int NCELL = QUOT_W;
    localparam int NSTG = 2 * NCELL + 2;       // input, chain, mid, chain

    // pipeline advance: frozen only while the skid holds a result
    logic w_en;
    logic [NSTG-1:0] r_v;
    logic r_skid_v;
    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    // ---------------- percent chain ----------------
    logic [NW-1:0]     w_prem [3][NCELL+1];
    logic [SW-1:0]     w_pden [3][NCELL+1];
    logic [QUOT_W-1:0] w_pq   [3][NCELL+1];
    t_pct_side         r_pside [NCELL+1];

    logic [SW-1:0] w_cnt [3];
    logic [NW-1:0] w_num [3];
    logic [NW-1:0] w_lim;
    logic [2:0]    w_clamp;
    logic [NW-1:0] r_num [3];
    logic [SW-1:0] r_clr;

    assign w_cnt[0] = i_red_count;
    assign w_cnt[1] = i_green_count;
    assign w_cnt[2] = i_blue_count;
    // at 128 percent or above the 7 bit quotient would overflow: clamp outright
    assign w_lim = NW'(i_clear_count) << QUOT_W;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_num[c]   = NW'(w_cnt[c]) * NW'(PCT_FULL);
            w_clamp[c] = (w_num[c] >= w_lim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_num[c] <= w_clamp[c] ? '0 : w_num[c];
            end
            r_clr            <= i_clear_count;
            r_pside[0].err   <= (i_clear_count == '0);
            r_pside[0].clamp <= w_clamp;
            for (int s = 1; s <= NCELL; s++) begin
                r_pside[s] <= r_pside[s-1];
            end
        end
    end

    genvar gc, gs;
    generate
        for (gc = 0; gc < 3; gc++) begin : g_pct
            assign w_prem[gc][0] = r_num[gc];
            assign w_pden[gc][0] = r_clr;
            assign w_pq[gc][0]   = '0;
            for (gs = 0; gs < NCELL; gs++) begin : g_cell
                rgbc_div_cell #(.W(NW), .DW(SW), .K(NCELL - 1 - gs)) u_cell (
                    .i_clk (i_clk),
                    .i_en  (w_en),
                    .i_rem (w_prem[gc][gs]),
                    .i_den (w_pden[gc][gs]),
                    .i_q   (w_pq[gc][gs]),
                    .o_rem (w_prem[gc][gs+1]),
                    .o_den (w_pden[gc][gs+1]),
                    .o_q   (w_pq[gc][gs+1])
                );
            end
        end
    endgenerate

    // ---------------- mid stage: max, min, sector ----------------
    logic [PCT_W-1:0] w_pct [3];
    logic [PCT_W-1:0] w_mx, w_mn, w_a, w_b, w_mag, w_dif;
    logic [HSL_DEN_W-1:0] w_sum, w_sden;
    logic [PCT_W-1:0] w_light;
    t_sector          w_sec;
    logic             w_neg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_pside[NCELL].clamp[c] || (w_pq[c][NCELL] > PCT_FULL)) begin
                w_pct[c] = PCT_FULL;
            end else begin
                w_pct[c] = w_pq[c][NCELL];
            end
        end
        // ties: red over green, green over blue
        if (w_pct[0] >= w_pct[1] && w_pct[0] >= w_pct[2]) begin
            w_sec = SEC_RED;
            w_mx  = w_pct[0];
            w_a   = w_pct[1];
            w_b   = w_pct[2];
        end else if (w_pct[1] >= w_pct[2]) begin
            w_sec = SEC_GREEN;
            w_mx  = w_pct[1];
            w_a   = w_pct[2];
            w_b   = w_pct[0];
        end else begin
            w_sec = SEC_BLUE;
            w_mx  = w_pct[2];
            w_a   = w_pct[0];
            w_b   = w_pct[1];
        end
        w_mn    = (w_a < w_b) ? w_a : w_b;
        w_neg   = (w_a < w_b);
        w_mag   = w_neg ? (w_b - w_a) : (w_a - w_b);
        w_dif   = w_mx - w_mn;
        w_sum   = HSL_DEN_W'(w_mx) + HSL_DEN_W'(w_mn);
        w_light = PCT_W'(w_sum >> 1);
        w_sden  = (w_light <= L_HALF) ? w_sum : (SUM_FULL - w_sum);
    end

    logic [HSL_REM_W-1:0] r_hnum, r_snum;
    logic [HSL_DEN_W-1:0] r_hden, r_sden;
    t_hsl_side            r_hside [NCELL+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hnum            <= HSL_REM_W'(w_mag) * HSL_REM_W'(HUE_SCALE);
            r_snum            <= HSL_REM_W'(w_dif) * HSL_REM_W'(PCT_FULL);
            r_hden            <= HSL_DEN_W'(w_dif);
            r_sden            <= w_sden;
            r_hside[0].err    <= r_pside[NCELL].err;
            r_hside[0].grey   <= (w_dif == '0);
            r_hside[0].neg    <= w_neg;
            r_hside[0].sector <= w_sec;
            r_hside[0].light  <= w_light;
            for (int s = 1; s <= NCELL; s++) begin
                r_hside[s] <= r_hside[s-1];
            end
        end
    end

    // ---------------- hue and saturation chain ----------------
    logic [HSL_REM_W-1:0] w_hrem [2][NCELL+1];
    logic [HSL_DEN_W-1:0] w_hden [2][NCELL+1];
    logic [QUOT_W-1:0]    w_hq   [2][NCELL+1];

    assign w_hrem[0][0] = r_hnum;
    assign w_hden[0][0] = r_hden;
    assign w_hrem[1][0] = r_snum;
    assign w_hden[1][0] = r_sden;

    generate
        for (gc = 0; gc < 2; gc++) begin : g_hsl
            assign w_hq[gc][0] = '0;
            for (gs = 0; gs < NCELL; gs++) begin : g_cell
                rgbc_div_cell #(.W(HSL_REM_W), .DW(HSL_DEN_W), .K(NCELL - 1 - gs)) u_cell (
                    .i_clk (i_clk),
                    .i_en  (w_en),
                    .i_rem (w_hrem[gc][gs]),
                    .i_den (w_hden[gc][gs]),
                    .i_q   (w_hq[gc][gs]),
                    .o_rem (w_hrem[gc][gs+1]),
                    .o_den (w_hden[gc][gs+1]),
                    .o_q   (w_hq[gc][gs+1])
                );
            end
        end
    endgenerate

    // ---------------- final assembly ----------------
    t_hsl_side        w_fs;
    logic [HUE_W-1:0] w_hq9, w_base, w_hue;
    logic [PCT_W-1:0] w_sat, w_lgt;

    always_comb begin
        w_fs  = r_hside[NCELL];
        w_hq9 = HUE_W'(w_hq[0][NCELL]);
        case (w_fs.sector)
            SEC_RED:   w_base = w_fs.neg ? HUE_RED : '0;
            SEC_GREEN: w_base = HUE_GREEN;
            SEC_BLUE:  w_base = HUE_BLUE;
            default:   w_base = '0;
        endcase
        w_hue = w_fs.neg ? (w_base - w_hq9) : (w_base + w_hq9);
        w_sat = w_hq[1][NCELL];
        w_lgt = w_fs.light;
        if (w_fs.err) begin
            w_hue = '0;
            w_sat = '0;
            w_lgt = '0;
        end else if (w_fs.grey) begin
            w_hue = '0;
            w_sat = '0;
        end
    end

    // ---------------- output register and skid ----------------
    logic r_out_v;
    logic [HUE_W-1:0] r_hue, r_skid_hue;
    logic [PCT_W-1:0] r_sat, r_lgt, r_skid_sat, r_skid_lgt;
    logic r_err, r_skid_err;
    logic w_tail_v;
    assign w_tail_v = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_en) begin
                r_v <= {r_v[NSTG-2:0], i_valid};
                if (!r_out_v || !i_stall) begin
                    r_out_v <= w_tail_v;
                end else if (w_tail_v) begin
                    r_skid_v <= 1'b1;
                end
            end else if (!i_stall) begin
                // skid drains into the output register
                r_skid_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_out_v || !i_stall) begin
                r_hue <= w_hue;
                r_sat <= w_sat;
                r_lgt <= w_lgt;
                r_err <= w_fs.err;
            end else begin
                r_skid_hue <= w_hue;
                r_skid_sat <= w_sat;
                r_skid_lgt <= w_lgt;
                r_skid_err <= w_fs.err;
            end
        end else if (!i_stall) begin
            r_hue <= r_skid_hue;
            r_sat <= r_skid_sat;
            r_lgt <= r_skid_lgt;
            r_err <= r_skid_err;
        end
    end

    assign o_valid        = r_out_v;
    assign o_hue          = r_hue;
    assign o_saturation   = r_sat;
    assign o_lightness    = r_lgt;
    assign o_divide_error = r_err;

    // skid only ever holds a result behind a waiting output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid full without output result");

    // draining the skid keeps a result on the output
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_stall) |=> (r_out_v && !r_skid_v))
        else $error("skid drain lost a result");

    // error results carry zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_err) |-> (r_hue == '0 && r_sat == '0 && r_lgt == '0))
        else $error("divide error with nonzero fields");

    // hue stays within 0..360
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_hue <= HUE_RED))
        else $error("hue out of range");
endmodule

>>> verif/rgbc_to_hsl_percent_chk.sv
// checker: watches both channels, predicts hsl results and compares them in order
`timescale 1ns / 1ps
module rgbc_to_hsl_percent_chk
    import rgbc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    i_in_stall,
    input  logic [SAMPLE_WIDTH-1:0] i_red_count,
    input  logic [SAMPLE_WIDTH-1:0] i_green_count,
    input  logic [SAMPLE_WIDTH-1:0] i_blue_count,
    input  logic [SAMPLE_WIDTH-1:0] i_clear_count,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [HUE_W-1:0]        i_hue,
    input  logic [PCT_W-1:0]        i_saturation,
    input  logic [PCT_W-1:0]        i_lightness,
    input  logic                    i_divide_error,
    output int                      o_fail_count,
    output int                      o_pending
);
    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] light;
        logic             err;
    } t_hsl;

    t_hsl hsl_queue[$];
    int   fail_count = 0;

    function automatic int unsigned pct_of(int unsigned ch, int unsigned clr);
        int unsigned p;
        p = (ch * 100) / clr;
        return (p > 100) ? 100 : p;
    endfunction

    // 60*(a-b)/den, truncated toward zero
    function automatic int hue_part(int unsigned a, int unsigned b, int unsigned den);
        if (a >= b) return int'((60 * (a - b)) / den);
        return -int'((60 * (b - a)) / den);
    endfunction

    function automatic t_hsl predict_hsl(int unsigned rc, int unsigned gc,
                                         int unsigned bc, int unsigned cc);
        t_hsl res;
        int unsigned r, g, b, mx, mn, dif, sum, l, s;
        int h;
        res = '0;
        if (cc == 0) begin
            res.err = 1'b1;
            return res;
        end
        r = pct_of(rc, cc);
        g = pct_of(gc, cc);
        b = pct_of(bc, cc);
        mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
        mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
        dif = mx - mn;
        sum = mx + mn;
        l = sum / 2;
        h = 0;
        s = 0;
        if (dif != 0) begin
            if (mx == r) begin
                h = hue_part(g, b, dif);
                if (g < b) h += 360;
            end else if (mx == g) begin
                h = hue_part(b, r, dif) + 120;
            end else begin
                h = hue_part(r, g, dif) + 240;
            end
            if (l <= 50) s = (dif * 100) / sum;
            else s = (dif * 100) / (200 - sum);
        end
        if (h < 0) h = 0;
        res.hue = h[HUE_W-1:0];
        res.sat = s[PCT_W-1:0];
        res.light = l[PCT_W-1:0];
        return res;
    endfunction

    assign o_fail_count = fail_count;

    always @(posedge i_clk) begin
        t_hsl want;
        if (i_rst_n) begin
            if (i_valid && !i_in_stall)
                hsl_queue.push_back(predict_hsl(i_red_count, i_green_count,
                                                i_blue_count, i_clear_count));
            if (i_out_valid && !i_out_stall) begin
                if (hsl_queue.size() == 0) begin
                    $error("result with no request pending");
                    fail_count++;
                end else begin
                    want = hsl_queue.pop_front();
                    if (want.hue !== i_hue) begin
                        $error("hue expected %0d actual %0d", want.hue, i_hue);
                        fail_count++;
                    end
                    if (want.sat !== i_saturation) begin
                        $error("saturation expected %0d actual %0d", want.sat, i_saturation);
                        fail_count++;
                    end
                    if (want.light !== i_lightness) begin
                        $error("lightness expected %0d actual %0d", want.light, i_lightness);
                        fail_count++;
                    end
                    if (want.err !== i_divide_error) begin
                        $error("divide_error expected %0d actual %0d", want.err,
                               i_divide_error);
                        fail_count++;
                    end
                end
            end
        end
        o_pending <= hsl_queue.size();
    end
endmodule

>>> verif/rgbc_to_hsl_percent_tb.sv
// testbench top: request stimulus, random idling and the final verdict
`timescale 1ns / 1ps
module rgbc_to_hsl_percent_tb
    import rgbc_pkg::*;
;
    localparam int SW = 16;
    localparam int N_RANDOM = 750;
    localparam int CALM_TAIL = 100;     // last requests sent with no idling
    localparam int WATCHDOG = 2000;     // idle cycles allowed before giving up
    localparam int DRAIN = 40;          // settle time after the last result

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [SW-1:0] red = '0, green = '0, blue = '0, clr = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat, light;
    logic          div_err;
    int            fail_count, pending;
    int            idle_cycles = 0;
    bit            calm = 1'b0;         // output stalls end after the current burst once set

    always #2 clk = ~clk;

    rgbc_to_hsl_percent #(.SAMPLE_WIDTH(SW)) uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_red_count(red), .i_green_count(green), .i_blue_count(blue),
        .i_clear_count(clr), .o_valid(out_valid), .i_stall(out_stall),
        .o_hue(hue), .o_saturation(sat), .o_lightness(light), .o_divide_error(div_err)
    );

    rgbc_to_hsl_percent_chk #(.SAMPLE_WIDTH(SW)) chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_red_count(red), .i_green_count(green), .i_blue_count(blue),
        .i_clear_count(clr), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_hue(hue), .i_saturation(sat), .i_lightness(light),
        .i_divide_error(div_err), .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog: counts cycles with no handshake on either channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stalls: out_stall is redrawn at random, high one time in three, until calm
    initial begin
        int n;
        @(posedge clk iff rst_n);
        while (!calm) begin
            n = $urandom_range(1, 12);
            out_stall <= ($urandom_range(0, 2) == 0);
            repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
    end

    // one request, held until accepted
    task automatic send_sample(logic [SW-1:0] r, logic [SW-1:0] g,
                               logic [SW-1:0] b, logic [SW-1:0] c);
        red <= r;
        green <= g;
        blue <= b;
        clr <= c;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic sender_gap();
        int n;
        n = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // random count, biased so percents land below, around and above full scale
    function automatic logic [SW-1:0] rand_count(logic [SW-1:0] c);
        case ($urandom_range(0, 5))
            0: return SW'($urandom());
            1: return '0;
            2: return c;
            default: return SW'($urandom_range(0, int'(c) + int'(c) / 4));
        endcase
    endfunction

    initial begin
        logic [SW-1:0] c;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: clear zero, grey, each sector, ties, clamping, extremes
        send_sample(16'd10, 16'd20, 16'd30, 16'd0);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        send_sample(16'd0, 16'd0, 16'd0, 16'd1);
        send_sample(16'd500, 16'd500, 16'd500, 16'd1000);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'hFFFF, 16'd0, 16'd0, 16'd1);
        send_sample(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        send_sample(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        send_sample(16'd900, 16'd200, 16'd500, 16'd1000);
        send_sample(16'd900, 16'd500, 16'd200, 16'd1000);
        send_sample(16'd300, 16'd800, 16'd100, 16'd1000);
        send_sample(16'd100, 16'd300, 16'd700, 16'd1000);
        send_sample(16'd700, 16'd700, 16'd100, 16'd1000);
        send_sample(16'd100, 16'd700, 16'd700, 16'd1000);
        send_sample(16'd700, 16'd100, 16'd700, 16'd1000);
        send_sample(16'd300, 16'd200, 16'd50000, 16'd100);
        send_sample(16'd990, 16'd980, 16'd10, 16'd1000);
        send_sample(16'd20, 16'd10, 16'd5, 16'd1000);
        send_sample(16'h5555, 16'hAAAA, 16'h0F0F, 16'hFFFE);
        send_sample(16'hAAAA, 16'h5555, 16'hF0F0, 16'h8000);
        send_sample(16'd1, 16'd0, 16'd0, 16'd1);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i >= N_RANDOM - CALM_TAIL) calm = 1'b1;
            c = ($urandom_range(0, 30) == 0) ? '0 : SW'($urandom_range(1, 65535));
            if ($urandom_range(0, 3) == 0) c = SW'($urandom_range(1, 300));
            send_sample(rand_count(c), rand_count(c), rand_count(c), c);
            if (!calm && $urandom_range(0, 5) == 0) sender_gap();
        end
        in_valid <= 1'b0;

        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

>>> rgbc_to_hsl_percent.f
design/rgbc_pkg.sv
design/rgbc_div_cell.sv
design/rgbc_to_hsl_percent.sv
verif/rgbc_to_hsl_percent_chk.sv
verif/rgbc_to_hsl_percent_tb.sv
